[rtl/f32sf_pkg.sv]
// Shared constants and types for the single-precision to fp12 converter.
package f32sf_pkg;

  // Result class carried down the pipeline
  typedef logic [1:0] kind_t;

  localparam kind_t KIND_ZERO = 2'd0;  // magnitude too small: signed zero
  localparam kind_t KIND_INF  = 2'd1;  // overflow or infinity
  localparam kind_t KIND_NAN  = 2'd2;  // not a number
  localparam kind_t KIND_FIN  = 2'd3;  // normal or subnormal fp12 result

  // Fixed output words
  localparam logic [15:0] SIGN_MASK = 16'hf800;
  localparam logic [15:0] POS_NAN   = 16'h07f1;
  localparam logic [15:0] NEG_NAN   = 16'hfff1;
  localparam logic [15:0] POS_INF   = 16'h07e0;
  localparam logic [15:0] NEG_INF   = 16'hffe0;

  // Single-precision exponent thresholds
  localparam logic [7:0] EXP_TINY_MAX = 8'd90;   // at or below: flush to zero
  localparam logic [7:0] EXP_SUB_MAX  = 8'd96;   // at or below: fp12 subnormal
  localparam logic [7:0] EXP_FIN_MAX  = 8'd158;  // above: infinity or NaN
  localparam logic [7:0] EXP_ALL_ONES = 8'hff;
  localparam logic [7:0] SUB_SHIFT_OFS = 8'd88;  // alignment shift base
  localparam logic [7:0] EXP_REBIAS    = 8'd96;  // single bias 127 to fp12 bias 31

  // Latency from accepted transaction to result strobe
  localparam int unsigned LATENCY = 3;

endpackage

[rtl/float32_to_small_float.sv]
// Three-stage pipelined single-precision to fp12 converter.
//
// Converts one IEEE single-precision bit pattern per clock into a 12-bit
// float in a 16-bit word (sign copied into bits 15..11, 6-bit exponent with
// bias 31, 5-bit fraction), rounding to nearest, ties to even. A transaction
// taken on start gives its result on small_float_word, marked by done, once it
// has passed the pipeline; results leave in the order the inputs came. The three
// pipeline registers (classify, align and round, assemble) let a new
// transaction enter every cycle, so busy is always low. The receiver cannot
// stall the block and must take each result in its one strobe cycle.
module float32_to_small_float (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] single_bits,
  output logic        done,
  output logic [15:0] small_float_word
);
  import f32sf_pkg::*;

  // ---------------- stage 1: classify ----------------
  logic [7:0]  in_ex;
  logic [22:0] in_man;
  logic [7:0]  shift_diff;
  logic [7:0]  rebias_diff;
  kind_t       in_kind;

  logic        s1_valid;
  logic        s1_neg;
  kind_t       s1_kind;
  logic        s1_is_sub;
  logic [3:0]  s1_shift;
  logic [5:0]  s1_ex_off;
  logic [22:0] s1_man;

  assign busy        = 1'b0;
  assign in_ex       = single_bits[30:23];
  assign in_man      = single_bits[22:0];
  assign shift_diff  = in_ex - SUB_SHIFT_OFS;
  assign rebias_diff = in_ex - EXP_REBIAS;

  // Range check on the exponent field
  always_comb begin
    priority if (in_ex <= EXP_TINY_MAX) begin
      in_kind = KIND_ZERO;
    end else if (in_ex > EXP_FIN_MAX) begin
      in_kind = (in_ex == EXP_ALL_ONES && in_man != 23'd0) ? KIND_NAN : KIND_INF;
    end else begin
      in_kind = KIND_FIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_neg    <= single_bits[31];
    s1_kind   <= in_kind;
    s1_is_sub <= (in_ex <= EXP_SUB_MAX);
    s1_shift  <= shift_diff[3:0];
    s1_ex_off <= rebias_diff[5:0];
    s1_man    <= in_man;
  end

  // ---------------- stage 2: align and round decision ----------------
  logic [31:0] whole;
  logic        sub_up;
  logic        norm_up;

  logic        s2_valid;
  logic        s2_neg;
  kind_t       s2_kind;
  logic [10:0] s2_base;
  logic        s2_up;

  // Subnormal: align the significand, keep 5 fraction bits, guard and sticky
  assign whole   = 32'({1'b1, s1_man}) << s1_shift;
  assign sub_up  = whole[26] & (whole[27] | (|whole[25:3]));
  assign norm_up = s1_man[17] & (s1_man[18] | (|s1_man[16:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_neg  <= s1_neg;
    s2_kind <= s1_kind;
    if (s1_is_sub) begin
      s2_base <= {6'd0, whole[31:27]};
      s2_up   <= sub_up;
    end else begin
      s2_base <= {s1_ex_off, s1_man[22:18]};
      s2_up   <= norm_up;
    end
  end

  // ---------------- stage 3: increment and assemble ----------------
  // A fraction carry runs into the exponent; carrying to the top exponent
  // yields exactly the infinity pattern.
  logic [10:0] rounded;
  logic [15:0] word_next;
  logic [15:0] sign_word;

  assign rounded   = s2_base + 11'(s2_up);
  assign sign_word = s2_neg ? SIGN_MASK : 16'd0;

  always_comb begin
    unique case (s2_kind)
      KIND_ZERO: word_next = sign_word;
      KIND_INF:  word_next = s2_neg ? NEG_INF : POS_INF;
      KIND_NAN:  word_next = s2_neg ? NEG_NAN : POS_NAN;
      default:   word_next = sign_word | {5'd0, rounded};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    small_float_word <= word_next;
  end

endmodule

[rtl/f32sf_checker.sv]
// Port-level checker for the fp12 converter, bound to the top level.
module f32sf_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [31:0] single_bits,
  input logic        done,
  input logic [15:0] small_float_word
);
  import f32sf_pkg::*;

  // Every accepted transaction gives a strobe after the pipeline latency
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("missing result strobe");

  // No strobe without an accepted transaction to match it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without transaction");

  // Output sign field is the replicated input sign
  a_sign: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3
      ((small_float_word[15:11] == 5'h1f && $past(single_bits[31], LATENCY)) ||
       (small_float_word[15:11] == 5'h00 && !$past(single_bits[31], LATENCY))))
    else $error("sign field wrong");

  // NaN input gives one of the two NaN words
  a_nan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && single_bits[30:23] == 8'hff && single_bits[22:0] != 23'd0)
      |-> ##3 (small_float_word == POS_NAN || small_float_word == NEG_NAN))
    else $error("NaN not preserved");

endmodule

bind float32_to_small_float f32sf_checker u_f32sf_checker (.*);
